// ----- sv/rcwc_pkg.sv -----
package rcwc_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] REG_PROJ  = 2'd0;
    localparam logic [1:0] REG_CEIL  = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;

    localparam logic [11:0] PROJ_RESET  = 12'd415;
    localparam logic [31:0] CEIL_RESET  = 32'hFF444444;
    localparam logic [31:0] FLOOR_RESET = 32'hFF888888;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROM,
        ST_MUL,
        ST_PERP,
        ST_DIV,
        ST_GEOM,
        ST_PXSEL,
        ST_TEXDIV,
        ST_TEXADDR,
        ST_TEXRD,
        ST_OUT
    } t_state;

    // Control from the sequencer to the shared restoring divider.
    typedef struct packed {
        logic        start;
        logic [37:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [37:0] quotient;
    } t_div_rsp;

    // Truncating 64-bit cosine series, exactly as the table is specified.
    function automatic logic [15:0] cos_entry(input int unsigned i, input int unsigned n);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [127:0] p;
        x = (64'(i) << 30) / 64'(n);
        p = 128'(x) * 128'(x);
        x2 = 64'(p >> 30);
        t = 64'd1 << 30;
        s = t;
        for (int k = 1; k <= 5; k++) begin
            p = 128'(t) * 128'(x2);
            t = 64'(p >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) s = s - t;
            else s = s + t;
        end
        return 16'((s + 64'd32768) >> 16);
    endfunction

    // floor(c*7/10) per channel through a reciprocal: (c*7*6554)>>16 with correction.
    function automatic logic [7:0] shade_ch(input logic [7:0] c);
        logic [10:0] m;
        logic [10:0] q;
        m = 11'(c) * 11'd7;
        q = 11'((24'(m) * 24'd6554) >> 16);
        if (m - q * 11'd10 >= 11'd10) q = q + 11'd1;
        if (m < q * 11'd10) q = q - 11'd1;
        return q[7:0];
    endfunction

endpackage

// ----- sv/rcwc_if.sv -----
interface rcwc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [14:0] texel_address;
    logic [31:0] texel_value;
    logic [8:0]  column_index;
    logic [19:0] hit_distance;
    logic signed [13:0] angle_offset;
    logic        hit_vertical;
    logic [11:0] hit_along_wall;
    logic [3:0]  wall_type;
    modport source(output valid, action, texel_address, texel_value, column_index,
                   hit_distance, angle_offset, hit_vertical, hit_along_wall, wall_type,
                   input ready);
    modport sink(input valid, action, texel_address, texel_value, column_index,
                 hit_distance, angle_offset, hit_vertical, hit_along_wall, wall_type,
                 output ready);
endinterface

interface rcwc_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  pixel_column;
    logic [8:0]  pixel_row;
    logic [31:0] pixel_color;
    logic        last_in_column;
    modport source(output valid, pixel_column, pixel_row, pixel_color, last_in_column,
                   input ready);
    modport sink(input valid, pixel_column, pixel_row, pixel_color, last_in_column,
                 output ready);
endinterface

// ----- sv/rcwc_ram.sv -----
module rcwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- sv/rcwc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rcwc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcwc_pkg::t_div_req i_req,
    output rcwc_pkg::t_div_rsp o_rsp
);
    logic [37:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_q[37]} - {1'b0, r_dvs};

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_q = i_req.dividend;
            n_rem = '0;
            n_dvs = i_req.divisor;
            n_cnt = 6'd38;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_q = {r_q[36:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[37]};
                n_q = {r_q[36:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_q;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == 6'd0 || $past(i_req.start) == 1'b0) else $error("count left");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("divider did not start");
`endif
endmodule

// ----- sv/raycast_wall_column_renderer.sv -----
// Textured wall column renderer. Action 0 writes one texel, action 1 opens a screen column
// from a ray hit, action 2 emits the next pixel of the open column from row 0 downward.
// Every item is handled one at a time and i_in.ready is low while it is in work. A texel
// write is done while idle. A column start passes ROM, MUL, PERP, the 38-step shared divider
// for the strip height (skipped for a zero perpendicular distance) and GEOM. Ceiling and floor
// pixels pass PXSEL and OUT; wall pixels also use the same divider for the texture row and
// read the texel before OUT. A finished pixel waits in the output register until it is taken;
// the next item is accepted meanwhile, and a following pixel holds in its last step until that
// register is free. The texture store is uninitialized after reset and has no clearing pass.
module raycast_wall_column_renderer #(
    parameter int SCREEN_ROWS    = 272,
    parameter int TILE_EDGE      = 64,
    parameter int TEXTURE_EDGE   = 64,
    parameter int TEXTURE_COUNT  = 8,
    parameter int COSINE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcwc_in_if.sink     i_in,
    rcwc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TW   = $clog2(TEXTURE_EDGE);
    localparam int SW   = $clog2(TEXTURE_COUNT) > 0 ? $clog2(TEXTURE_COUNT) : 1;
    localparam int AW   = $clog2(TEXTURE_COUNT * TEXTURE_EDGE * TEXTURE_EDGE);
    localparam int DEPTH = TEXTURE_COUNT * TEXTURE_EDGE * TEXTURE_EDGE;
    localparam int CW   = $clog2(COSINE_ENTRIES);
    localparam int MID  = SCREEN_ROWS / 2;
    localparam int RW   = 10;

    // Configuration registers
    logic [11:0] r_proj;
    logic [31:0] r_ceil, r_floor;
    logic        w_cfg_wr;
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj <= rcwc_pkg::PROJ_RESET;
            r_ceil <= rcwc_pkg::CEIL_RESET;
            r_floor <= rcwc_pkg::FLOOR_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                rcwc_pkg::REG_PROJ:  r_proj <= pwdata[11:0];
                rcwc_pkg::REG_CEIL:  r_ceil <= pwdata;
                rcwc_pkg::REG_FLOOR: r_floor <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rcwc_pkg::REG_PROJ:  prdata = {20'd0, r_proj};
            rcwc_pkg::REG_CEIL:  prdata = r_ceil;
            rcwc_pkg::REG_FLOOR: prdata = r_floor;
            default:             prdata = '0;
        endcase
    end

    // Cosine ROM
    logic [15:0] c_cos [COSINE_ENTRIES];
    always_comb begin
        for (int i = 0; i < COSINE_ENTRIES; i++) begin
            c_cos[i] = rcwc_pkg::cos_entry(i, COSINE_ENTRIES);
        end
    end

    // State
    rcwc_pkg::t_state r_state, n_state;
    logic [15:0] r_h, n_h;
    logic [RW-1:0] r_top, n_top, r_bot, n_bot, r_row, n_row;
    logic [TW-1:0] r_tcol, n_tcol, r_ty, n_ty;
    logic [SW-1:0] r_tsel, n_tsel;
    logic        r_shade, n_shade, r_active, n_active;
    logic [8:0]  r_col, n_col;
    logic [19:0] r_dist, n_dist;
    logic [13:0] r_mag, n_mag;
    logic [15:0] r_cosv, n_cosv;
    logic [35:0] r_prod, n_prod;
    logic [1:0]  r_kind, n_kind;
    logic        r_ovalid, n_ovalid;
    logic [8:0]  r_ocol, n_ocol;
    logic [8:0]  r_orow, n_orow;
    logic [31:0] r_ocolor, n_ocolor;
    logic        r_olast, n_olast;
    logic        w_ready;

    localparam logic [1:0] K_CEIL = 2'd0, K_WALL = 2'd1, K_FLOOR = 2'd2;

    rcwc_pkg::t_div_req w_dreq;
    rcwc_pkg::t_div_rsp w_drsp;
    rcwc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;
    rcwc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tex (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_in.texel_address[AW-1:0]),
        .i_wdata(i_in.texel_value), .i_raddr(w_raddr), .o_rdata(w_rdata));

    assign w_ready = (r_state == rcwc_pkg::ST_IDLE);
    assign i_in.ready = w_ready;
    assign w_we = w_ready && i_in.valid && i_in.action == rcwc_pkg::ACT_WRITE
                  && 32'(i_in.texel_address) < 32'(DEPTH);
    assign w_raddr = AW'({r_tsel, r_ty, r_tcol});

    logic [31:0] w_idx;
    logic [15:0] w_half;
    logic [RW:0] w_bsum;
    logic [16:0] w_d;
    logic [3:0]  w_wt;
    logic [31:0] w_shaded;

    always_comb begin
        w_idx = (32'(r_mag) * 32'(COSINE_ENTRIES)) >> 13;
        w_half = r_h >> 1;
        w_bsum = (RW+1)'(MID) + (RW+1)'(w_half > 16'(SCREEN_ROWS) ? 16'(SCREEN_ROWS) : w_half);
        // Offset into the strip can reach half the largest height, so it keeps 17 bits.
        w_d = 17'(32'(r_row) + 32'(w_half) - 32'(MID));
        w_wt = i_in.wall_type;
        w_shaded = {w_rdata[31:24], rcwc_pkg::shade_ch(w_rdata[23:16]),
                    rcwc_pkg::shade_ch(w_rdata[15:8]), rcwc_pkg::shade_ch(w_rdata[7:0])};
    end

    always_comb begin
        n_state = r_state;
        n_h = r_h; n_top = r_top; n_bot = r_bot; n_row = r_row;
        n_tcol = r_tcol; n_ty = r_ty; n_tsel = r_tsel; n_shade = r_shade;
        n_active = r_active; n_col = r_col; n_dist = r_dist; n_mag = r_mag;
        n_cosv = r_cosv; n_prod = r_prod; n_kind = r_kind;
        n_ovalid = r_ovalid; n_ocol = r_ocol; n_orow = r_orow; n_ocolor = r_ocolor;
        n_olast = r_olast;
        w_dreq = '0;
        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;
        unique case (r_state)
            rcwc_pkg::ST_IDLE: begin
                if (w_ready && i_in.valid) begin
                    if (i_in.action == rcwc_pkg::ACT_START) begin
                        n_mag = i_in.angle_offset[13] ? 14'(-i_in.angle_offset)
                                                      : i_in.angle_offset;
                        n_dist = i_in.hit_distance;
                        n_col = i_in.column_index;
                        n_shade = i_in.hit_vertical;
                        n_tcol = TW'(32'(i_in.hit_along_wall % 12'(TILE_EDGE))
                                     * TEXTURE_EDGE / TILE_EDGE);
                        if (w_wt == 4'd0) n_tsel = '0;
                        else if (32'(w_wt) > TEXTURE_COUNT) n_tsel = SW'(TEXTURE_COUNT - 1);
                        else n_tsel = SW'(w_wt - 4'd1);
                        n_active = 1'b0;
                        n_state = rcwc_pkg::ST_ROM;
                    end else if (i_in.action == rcwc_pkg::ACT_PIXEL && r_active) begin
                        n_state = rcwc_pkg::ST_PXSEL;
                    end
                end
            end
            rcwc_pkg::ST_ROM: begin
                n_cosv = c_cos[w_idx >= 32'(COSINE_ENTRIES) ? CW'(COSINE_ENTRIES - 1)
                                                            : w_idx[CW-1:0]];
                n_state = rcwc_pkg::ST_MUL;
            end
            rcwc_pkg::ST_MUL: begin
                n_prod = 36'(r_dist) * 36'(r_cosv);
                n_state = rcwc_pkg::ST_PERP;
            end
            rcwc_pkg::ST_PERP: begin
                if (r_prod[35:14] == 22'd0) begin
                    n_h = 16'hFFFF;
                    n_state = rcwc_pkg::ST_GEOM;
                end else begin
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = 38'(32'(r_proj) * TILE_EDGE * 256);
                    w_dreq.divisor = 32'(r_prod[35:14]);
                    n_state = rcwc_pkg::ST_DIV;
                end
            end
            rcwc_pkg::ST_DIV: begin
                if (w_drsp.done) begin
                    n_h = w_drsp.quotient > 38'hFFFF ? 16'hFFFF : w_drsp.quotient[15:0];
                    n_state = rcwc_pkg::ST_GEOM;
                end
            end
            rcwc_pkg::ST_GEOM: begin
                n_top = (w_half >= 16'(MID)) ? '0 : RW'(16'(MID) - w_half);
                n_bot = (w_bsum > (RW+1)'(SCREEN_ROWS)) ? RW'(SCREEN_ROWS) : RW'(w_bsum);
                n_row = '0;
                n_active = 1'b1;
                n_state = rcwc_pkg::ST_IDLE;
            end
            rcwc_pkg::ST_PXSEL: begin
                priority if (r_row < r_top) begin
                    n_kind = K_CEIL;
                    n_state = rcwc_pkg::ST_OUT;
                end else if (r_row < r_bot && r_h != 16'd0) begin
                    n_kind = K_WALL;
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = 38'(w_d) * 38'(TEXTURE_EDGE);
                    w_dreq.divisor = 32'(r_h);
                    n_state = rcwc_pkg::ST_TEXDIV;
                end else begin
                    n_kind = K_FLOOR;
                    n_state = rcwc_pkg::ST_OUT;
                end
            end
            rcwc_pkg::ST_TEXDIV: begin
                if (w_drsp.done) begin
                    n_ty = (w_drsp.quotient > 38'(TEXTURE_EDGE - 1)) ? TW'(TEXTURE_EDGE - 1)
                                                                    : w_drsp.quotient[TW-1:0];
                    n_state = rcwc_pkg::ST_TEXADDR;
                end
            end
            rcwc_pkg::ST_TEXADDR: n_state = rcwc_pkg::ST_TEXRD;
            rcwc_pkg::ST_TEXRD: n_state = rcwc_pkg::ST_OUT;
            rcwc_pkg::ST_OUT: begin
                // Hold here until the previous pixel has left the output register.
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ocol = r_col;
                    n_orow = r_row[8:0];
                    n_olast = 32'(r_row) >= SCREEN_ROWS - 1;
                    unique case (r_kind)
                        K_CEIL:  n_ocolor = r_ceil;
                        K_WALL:  n_ocolor = r_shade ? w_shaded : w_rdata;
                        default: n_ocolor = r_floor;
                    endcase
                    if (32'(r_row) >= SCREEN_ROWS - 1) n_active = 1'b0;
                    else n_row = r_row + RW'(1);
                    n_state = rcwc_pkg::ST_IDLE;
                end
            end
            default: n_state = rcwc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcwc_pkg::ST_IDLE;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_h <= '0; r_top <= '0; r_bot <= '0; r_row <= '0;
            r_tcol <= '0; r_tsel <= '0; r_shade <= 1'b0; r_col <= '0;
        end else begin
            r_state <= n_state;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
            r_h <= n_h; r_top <= n_top; r_bot <= n_bot; r_row <= n_row;
            r_tcol <= n_tcol; r_tsel <= n_tsel; r_shade <= n_shade; r_col <= n_col;
        end
        r_ty <= n_ty; r_dist <= n_dist; r_mag <= n_mag; r_cosv <= n_cosv;
        r_prod <= n_prod; r_kind <= n_kind;
        r_ocol <= n_ocol; r_orow <= n_orow; r_ocolor <= n_ocolor; r_olast <= n_olast;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.pixel_column = r_ocol;
    assign o_out.pixel_row = r_orow;
    assign o_out.pixel_color = r_ocolor;
    assign o_out.last_in_column = r_olast;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != rcwc_pkg::ST_IDLE |-> !i_in.ready) else $error("ready while busy");
    a_top_le_bot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_top <= r_bot) else $error("wall rows out of order");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !$past(r_ovalid) && r_olast |-> !r_active) else $error("column left open");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> 32'(r_row) < SCREEN_ROWS) else $error("row past screen");
`endif
endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS      = 272;
    localparam int MID_ROW   = ROWS / 2;
    localparam int TEX_EDGE  = 64;
    localparam int STORE_SZ  = 32768;
    localparam int COS_SZ    = 1024;
    localparam int IDLE_WAIT = 60;

    typedef struct {
        logic [1:0]  action;
        logic [14:0] texel_address;
        logic [31:0] texel_value;
        logic [8:0]  column_index;
        logic [19:0] hit_distance;
        logic [13:0] angle_offset;
        logic        hit_vertical;
        logic [11:0] hit_along_wall;
        logic [3:0]  wall_type;
    } t_ray_item;

    typedef struct {
        logic [8:0]  column;
        logic [8:0]  row;
        logic [31:0] color;
        logic        last;
    } t_pixel;

    class pixel_scoreboard;
        logic [31:0] texels [0:STORE_SZ-1];
        logic [15:0] cos_tab [0:COS_SZ-1];
        t_pixel      pending_pixels [$];
        int          errors;
        logic [11:0] proj_dist;
        logic [31:0] ceil_color;
        logic [31:0] floor_color;
        int unsigned height;
        int unsigned top_row;
        int unsigned bottom_row;
        int unsigned tex_col;
        int unsigned tex_sel;
        bit          darken;
        int unsigned row_now;
        logic [8:0]  col_now;
        bit          open;

        function new();
            logic [127:0] prod;
            logic [63:0]  x;
            logic [63:0]  xsq;
            logic [63:0]  term;
            logic [63:0]  acc;
            for (int i = 0; i < COS_SZ; i++) begin
                x = (64'(i) << 30) / COS_SZ;
                prod = 128'(x) * 128'(x);
                xsq = 64'(prod >> 30);
                term = 64'd1 << 30;
                acc = term;
                for (int k = 1; k <= 5; k++) begin
                    prod = 128'(term) * 128'(xsq);
                    term = 64'(prod >> 30) / 64'((2 * k - 1) * (2 * k));
                    acc = (k % 2 == 1) ? acc - term : acc + term;
                end
                cos_tab[i] = 16'((acc + 64'd32768) >> 16);
            end
            errors = 0;
            proj_dist = rcwc_pkg::PROJ_RESET;
            ceil_color = rcwc_pkg::CEIL_RESET;
            floor_color = rcwc_pkg::FLOOR_RESET;
            height = 0; top_row = 0; bottom_row = 0; tex_col = 0; tex_sel = 0;
            darken = 0; row_now = 0; col_now = '0; open = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                rcwc_pkg::REG_PROJ:  proj_dist = val[11:0];
                rcwc_pkg::REG_CEIL:  ceil_color = val;
                rcwc_pkg::REG_FLOOR: floor_color = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] dim(logic [7:0] c);
            return 8'((int'(c) * 7) / 10);
        endfunction

        function void note_input(t_ray_item it);
            int unsigned mag;
            int unsigned idx;
            longint unsigned perp;
            longint unsigned h;
            int unsigned half;
            int unsigned wt;
            int unsigned d;
            int unsigned ty;
            logic [31:0] c;
            t_pixel px;
            case (it.action)
                rcwc_pkg::ACT_WRITE: texels[it.texel_address] = it.texel_value;
                rcwc_pkg::ACT_START: begin
                    mag = it.angle_offset[13] ? 32'h4000 - it.angle_offset : it.angle_offset;
                    idx = (mag * COS_SZ) >> 13;
                    if (idx >= COS_SZ) idx = COS_SZ - 1;
                    perp = (longint'(it.hit_distance) * cos_tab[idx]) >> 14;
                    if (perp == 0) h = 65535;
                    else begin
                        h = (longint'(proj_dist) * TEX_EDGE * 256) / perp;
                        if (h > 65535) h = 65535;
                    end
                    height = h;
                    half = height / 2;
                    top_row = (half >= MID_ROW) ? 0 : MID_ROW - half;
                    bottom_row = (MID_ROW + half > ROWS) ? ROWS : MID_ROW + half;
                    tex_col = it.hit_along_wall % 64;
                    wt = it.wall_type;
                    if (wt == 0) wt = 1;
                    if (wt > 8) wt = 8;
                    tex_sel = wt - 1;
                    darken = it.hit_vertical;
                    col_now = it.column_index;
                    row_now = 0;
                    open = 1;
                end
                rcwc_pkg::ACT_PIXEL: begin
                    if (open) begin
                        if (row_now < top_row) c = ceil_color;
                        else if (row_now < bottom_row && height != 0) begin
                            d = row_now + height / 2 - MID_ROW;
                            ty = (longint'(d) * TEX_EDGE) / height;
                            if (ty > TEX_EDGE - 1) ty = TEX_EDGE - 1;
                            c = texels[tex_sel * 4096 + ty * TEX_EDGE + tex_col];
                            if (darken) c = {c[31:24], dim(c[23:16]), dim(c[15:8]), dim(c[7:0])};
                        end else c = floor_color;
                        px.column = col_now;
                        px.row = 9'(row_now);
                        px.color = c;
                        px.last = (row_now >= ROWS - 1);
                        pending_pixels.push_back(px);
                        if (px.last) open = 0;
                        else row_now++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel col %0d row %0d color %h", $realtime,
                         got.column, got.row, got.color);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.column !== want.column) begin
                $display("%0t: pixel_column exp %0d got %0d", $realtime, want.column, got.column);
                errors++;
            end
            if (got.row !== want.row) begin
                $display("%0t: pixel_row exp %0d got %0d", $realtime, want.row, got.row);
                errors++;
            end
            if (got.color !== want.color) begin
                $display("%0t: pixel_color exp %h got %h (row %0d)", $realtime, want.color,
                         got.color, want.row);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_in_column exp %0d got %0d", $realtime, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rcwc_in_if  ray_ch();
    rcwc_out_if pix_ch();

    raycast_wall_column_renderer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ray_ch.sink),
        .o_out   (pix_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pixel_scoreboard sb = new();
    bit gaps_on;
    bit burst_mode;
    // Texels already written, so that no pixel ever reads an unwritten one.
    bit texel_set [STORE_SZ];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // Both transfers are sampled here; inputs are noted before outputs are checked.
    always @(posedge i_clk) begin
        t_ray_item it;
        t_pixel px;
        if (i_rst_n && ray_ch.valid && ray_ch.ready) begin
            it.action = ray_ch.action;
            it.texel_address = ray_ch.texel_address;
            it.texel_value = ray_ch.texel_value;
            it.column_index = ray_ch.column_index;
            it.hit_distance = ray_ch.hit_distance;
            it.angle_offset = ray_ch.angle_offset;
            it.hit_vertical = ray_ch.hit_vertical;
            it.hit_along_wall = ray_ch.hit_along_wall;
            it.wall_type = ray_ch.wall_type;
            sb.note_input(it);
        end
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            px.column = pix_ch.pixel_column;
            px.row = pix_ch.pixel_row;
            px.color = pix_ch.pixel_color;
            px.last = pix_ch.last_in_column;
            sb.check_pixel(px);
        end
    end

    function automatic int draw_gap();
        if (!gaps_on) return 0;
        if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
        return burst_mode ? 0 : $urandom_range(0, 16);
    endfunction

    // Receiver stall process.
    initial begin
        int stall;
        pix_ch.ready <= 1'b0;
        @(negedge i_clk);
        wait (i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
            @(negedge i_clk);
        end
    end

    task automatic send(t_ray_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ray_ch.action <= it.action;
        ray_ch.texel_address <= it.texel_address;
        ray_ch.texel_value <= it.texel_value;
        ray_ch.column_index <= it.column_index;
        ray_ch.hit_distance <= it.hit_distance;
        ray_ch.angle_offset <= it.angle_offset;
        ray_ch.hit_vertical <= it.hit_vertical;
        ray_ch.hit_along_wall <= it.hit_along_wall;
        ray_ch.wall_type <= it.wall_type;
        ray_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!ray_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Quiet the input side and wait until every pixel has been transferred.
    task automatic drain();
        ray_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    function automatic t_ray_item rand_item(logic [1:0] act);
        t_ray_item it;
        it.action = act;
        it.texel_address = 15'($urandom);
        it.texel_value = $urandom;
        it.column_index = 9'($urandom);
        case ($urandom_range(0, 9))
            0:       it.hit_distance = '0;
            1, 2, 3: it.hit_distance = 20'($urandom);
            4:       it.hit_distance = 20'($urandom_range(0, 4000));
            default: it.hit_distance = 20'($urandom_range(15000, 60000));
        endcase
        it.angle_offset = 14'($urandom);
        it.hit_vertical = 1'($urandom);
        it.hit_along_wall = 12'($urandom);
        it.wall_type = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        return it;
    endfunction

    // Write every texel of the texture column that a column start will read, if not yet set.
    task automatic fill_column(t_ray_item st, output int n_wr);
        t_ray_item it;
        int unsigned wt;
        int unsigned addr;
        n_wr = 0;
        wt = st.wall_type;
        if (wt == 0) wt = 1;
        if (wt > 8) wt = 8;
        it = rand_item(rcwc_pkg::ACT_WRITE);
        for (int r = 0; r < TEX_EDGE; r++) begin
            addr = (wt - 1) * 4096 + r * TEX_EDGE + st.hit_along_wall % TEX_EDGE;
            if (!texel_set[addr]) begin
                it.texel_address = 15'(addr);
                it.texel_value = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF :
                                 ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
                send(it);
                texel_set[addr] = 1'b1;
                n_wr++;
            end
        end
    endtask

    task automatic start_column(t_ray_item st, output int n_wr);
        fill_column(st, n_wr);
        send(st);
    endtask

    task automatic pixels(int n);
        t_ray_item it;
        it = rand_item(rcwc_pkg::ACT_PIXEL);
        repeat (n) send(it);
    endtask

    task automatic random_phase(int n_items);
        int cnt;
        int n;
        int nw;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                start_column(rand_item(rcwc_pkg::ACT_START), nw);
                n = ($urandom_range(0, 5) == 0) ? ROWS : $urandom_range(1, 80);
                pixels(n);
                cnt += n + 1 + nw;
            end else begin
                case ($urandom_range(0, 2))
                    0: send(rand_item(rcwc_pkg::ACT_WRITE));
                    1: send(rand_item(rcwc_pkg::ACT_NONE));
                    default: send(rand_item(rcwc_pkg::ACT_PIXEL));
                endcase
                cnt++;
            end
        end
    endtask

    initial begin
        t_ray_item it;
        int nw;
        gaps_on = 0;
        burst_mode = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ray_ch.valid = 1'b0;
        ray_ch.action = rcwc_pkg::ACT_WRITE;
        ray_ch.texel_address = '0;
        ray_ch.texel_value = '0;
        ray_ch.column_index = '0;
        ray_ch.hit_distance = '0;
        ray_ch.angle_offset = '0;
        ray_ch.hit_vertical = 1'b0;
        ray_ch.hit_along_wall = '0;
        ray_ch.wall_type = 4'd1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gaps_on = 1;

        // Directed part: pixel with no open column, unused action, then edge-case columns.
        send(rand_item(rcwc_pkg::ACT_PIXEL));
        send(rand_item(rcwc_pkg::ACT_NONE));
        it = rand_item(rcwc_pkg::ACT_START);
        it.hit_distance = '0;
        it.angle_offset = 14'h2000;
        it.wall_type = 4'd0;
        it.column_index = 9'd511;
        it.hit_vertical = 1'b1;
        it.hit_along_wall = 12'hFFF;
        start_column(it, nw);
        pixels(3);
        it.hit_distance = 20'hFFFFF;
        it.angle_offset = 14'h1FFF;
        it.wall_type = 4'd15;
        it.hit_vertical = 1'b0;
        it.column_index = '0;
        it.hit_along_wall = '0;
        start_column(it, nw);
        pixels(3);
        it.hit_distance = 20'd30000;
        it.angle_offset = '0;
        it.wall_type = 4'd8;
        it.hit_vertical = 1'b1;
        start_column(it, nw);
        pixels(4);
        it.wall_type = 4'd9;
        it.angle_offset = 14'h3FFF;
        start_column(it, nw);
        pixels(4);

        random_phase(400);
        drain();
        write_reg(rcwc_pkg::REG_PROJ, 32'd4095);
        write_reg(rcwc_pkg::REG_CEIL, 32'h0);
        write_reg(rcwc_pkg::REG_FLOOR, 32'hFFFF_FFFF);
        random_phase(400);
        drain();
        write_reg(rcwc_pkg::REG_PROJ, 32'd1);
        write_reg(rcwc_pkg::REG_CEIL, 32'hFFFF_FFFF);
        write_reg(rcwc_pkg::REG_FLOOR, 32'h0);
        random_phase(300);
        drain();
        // A zero projection distance flattens every strip except at zero distance.
        write_reg(rcwc_pkg::REG_PROJ, 32'd0);
        random_phase(200);
        drain();
        write_reg(rcwc_pkg::REG_PROJ, 32'($urandom_range(1, 4095)));
        write_reg(rcwc_pkg::REG_CEIL, $urandom);
        write_reg(rcwc_pkg::REG_FLOOR, $urandom);
        random_phase(400);
        drain();
        write_reg(rcwc_pkg::REG_PROJ, 32'(rcwc_pkg::PROJ_RESET));
        write_reg(rcwc_pkg::REG_CEIL, rcwc_pkg::CEIL_RESET);
        write_reg(rcwc_pkg::REG_FLOOR, rcwc_pkg::FLOOR_RESET);
        random_phase(300);
        drain();

        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
